// ===== rtl/core/et_pkg.sv =====
// ----------------------------------------------------------------------------
// et_pkg
// Shared constants and types for the totient core: widths, controller
// states, divider operand selects and the controller/datapath interface.
// ----------------------------------------------------------------------------
package et_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IN_WIDTH   = 32;
  localparam int unsigned OUT_WIDTH  = 32;
  localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    DIV_REST_BY_D,
    DIV_ACC_BY_D,
    DIV_ACC_BY_REST
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST_GO,
    ST_TEST_WAIT,
    ST_STRIP_GO,
    ST_STRIP_WAIT,
    ST_ACC_GO,
    ST_ACC_WAIT,
    ST_FIN_CHK,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic     load;         // capture input item, d = 2
    logic     div_start;
    div_sel_e div_sel;
    logic     rest_from_q;  // rest <= quotient
    logic     d_inc;
    logic     acc_mul;      // acc <= quotient * (factor - 1)
    logic     mul_rest;     // factor is rest, else d
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic bound_fail;       // d > rest / d
    logic rem_zero;
    logic rest_gt1;
  } dp_status_t;

endpackage

// ===== rtl/core/et_div.sv =====
// ----------------------------------------------------------------------------
// et_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder
// hold after done until the next start.
// ----------------------------------------------------------------------------
module et_div
  import et_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output data_t quot_o,
  output data_t rem_o,
  output logic  busy_o,
  output logic  done_o
);

  data_t                 quot_q, rem_q, divisor_q;
  logic [CNT_WIDTH-1:0]  cnt_q;
  logic                  busy_q, done_q;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  assign shifted = {rem_q, quot_q[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
      cnt_q     <= CNT_WIDTH'(DATA_WIDTH - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (!diff[DATA_WIDTH]) begin
        rem_q  <= diff[DATA_WIDTH-1:0];
        quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_q  <= shifted[DATA_WIDTH-1:0];
        quot_q <= {quot_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/et_datapath.sv =====
// ----------------------------------------------------------------------------
// et_datapath
// Cofactor, running totient and trial divisor registers around the shared
// divider and the (p-1) scaling multiplier.
// ----------------------------------------------------------------------------
module et_datapath
  import et_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [IN_WIDTH-1:0]  number_i,
  output dp_status_t           status_o,
  output logic [OUT_WIDTH-1:0] totient_o
);

  data_t                 rest_q, acc_q, d_q, totient_q;
  data_t                 dividend, divisor, quot, rem, factor;
  logic                  div_busy, div_done;
  logic [2*DATA_WIDTH-1:0] prod;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_REST_BY_D: begin
        dividend = rest_q;
        divisor  = d_q;
      end
      DIV_ACC_BY_D: begin
        dividend = acc_q;
        divisor  = d_q;
      end
      DIV_ACC_BY_REST: begin
        dividend = acc_q;
        divisor  = rest_q;
      end
      default: begin
        dividend = rest_q;
        divisor  = d_q;
      end
    endcase
  end

  et_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .rem_o      (rem),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  // acc / p is exact, so the low half of the product is the scaled result
  assign factor = (cmd_i.mul_rest ? rest_q : d_q) - 1'b1;
  assign prod   = {{DATA_WIDTH{1'b0}}, quot} * {{DATA_WIDTH{1'b0}}, factor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q    <= '0;
      acc_q     <= '0;
      d_q       <= DATA_WIDTH'(2);
      totient_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rest_q <= DATA_WIDTH'(number_i);
        acc_q  <= DATA_WIDTH'(number_i);
        d_q    <= DATA_WIDTH'(2);
      end else begin
        if (cmd_i.rest_from_q) rest_q <= quot;
        if (cmd_i.acc_mul)     acc_q  <= prod[DATA_WIDTH-1:0];
        if (cmd_i.d_inc)       d_q    <= d_q + 1'b1;
      end
      if (cmd_i.out_load) totient_q <= acc_q;
    end
  end

  assign status_o.div_busy   = div_busy;
  assign status_o.div_done   = div_done;
  assign status_o.bound_fail = d_q > quot;
  assign status_o.rem_zero   = (rem == '0);
  assign status_o.rest_gt1   = rest_q > DATA_WIDTH'(1);

  assign totient_o = OUT_WIDTH'(totient_q);

endmodule

// ===== rtl/core/et_ctrl.sv =====
// ----------------------------------------------------------------------------
// et_ctrl
// Trial division sequencer and output handshake.
// ----------------------------------------------------------------------------
module et_ctrl
  import et_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.div_sel = DIV_REST_BY_D;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TEST_GO;
        end
      end
      ST_TEST_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_TEST_WAIT;
      end
      ST_TEST_WAIT: begin
        if (status_i.div_done) begin
          priority if (status_i.bound_fail) begin
            state_d = ST_FIN_CHK;
          end else if (status_i.rem_zero) begin
            cmd_o.rest_from_q = 1'b1;
            state_d           = ST_STRIP_GO;
          end else begin
            cmd_o.d_inc = 1'b1;
            state_d     = ST_TEST_GO;
          end
        end
      end
      ST_STRIP_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_STRIP_WAIT;
      end
      ST_STRIP_WAIT: begin
        if (status_i.div_done) begin
          if (status_i.rem_zero) begin
            cmd_o.rest_from_q = 1'b1;
            state_d           = ST_STRIP_GO;
          end else begin
            state_d = ST_ACC_GO;
          end
        end
      end
      ST_ACC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ACC_BY_D;
        state_d         = ST_ACC_WAIT;
      end
      ST_ACC_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.acc_mul = 1'b1;
          cmd_o.d_inc   = 1'b1;
          state_d       = ST_TEST_GO;
        end
      end
      ST_FIN_CHK: begin
        state_d = status_i.rest_gt1 ? ST_FIN_GO : ST_DONE;
      end
      ST_FIN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ACC_BY_REST;
        state_d         = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.acc_mul  = 1'b1;
          cmd_o.mul_rest = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register free or draining this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/euler_totient.sv =====
// Cost: a divisor that does not divide costs one divider pass; a prime factor
//   p^k costs k+2 passes.
// Throughput: one item at a time; worst case near 65536 trial divisors, each
//   tried on the shared one-bit-per-cycle divider.
// The next item is taken while a finished result waits in the output register.
// Reset: asynchronous, active low; clears controller state and output valid.
// ----------------------------------------------------------------------------
// euler_totient
// Euler totient by trial division: controller plus divider datapath.
// ----------------------------------------------------------------------------
module euler_totient
  import et_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_WIDTH-1:0]  number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_WIDTH-1:0] totient_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  et_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  et_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .number_i  (number_i),
    .status_o  (status),
    .totient_o (totient_o)
  );

`ifndef SYNTHESIS
  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status.div_busy)
    else $error("divider busy while accepting items");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> $past(status.div_busy))
    else $error("divider done without a pass");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted mid pass");
`endif

endmodule
